[hdl/tfvc_pkg.sv]
// ---------------------------------------------------------------------------
// tfvc_pkg: shared types and constants of the target follow controller
// Register indexes, fixed-point constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package tfvc_pkg;

   localparam int RegCount = 8;

   typedef enum logic [2:0] {
      REG_TARGET_DIST = 3'd0,
      REG_STOP_DIST   = 3'd1,
      REG_MAX_LIN     = 3'd2,
      REG_MAX_ANG     = 3'd3,
      REG_DECAY_LIN   = 3'd4,
      REG_DECAY_ANG   = 3'd5,
      REG_BLEND_LIN   = 3'd6,
      REG_BLEND_ANG   = 3'd7
   } reg_index_type;

   localparam logic signed [15:0] AngLimit     = 16'sd12868;
   localparam logic signed [23:0] QuarterPiQ16 = 24'sd102944;
   localparam logic [29:0]        Ln2Q30       = 30'd744261118;
   localparam logic [16:0]        ExpScale     = 17'd96817;

   // atan(2^-i) in Q.16
   function automatic logic signed [23:0] atan_entry(input logic [3:0] idx);
      logic signed [23:0] v;
      case (idx)
         4'd0:  v = 24'sd51472;
         4'd1:  v = 24'sd30386;
         4'd2:  v = 24'sd16055;
         4'd3:  v = 24'sd8150;
         4'd4:  v = 24'sd4091;
         4'd5:  v = 24'sd2047;
         4'd6:  v = 24'sd1024;
         4'd7:  v = 24'sd512;
         4'd8:  v = 24'sd256;
         4'd9:  v = 24'sd128;
         4'd10: v = 24'sd64;
         4'd11: v = 24'sd32;
         4'd12: v = 24'sd16;
         4'd13: v = 24'sd8;
         4'd14: v = 24'sd4;
         4'd15: v = 24'sd2;
         default: v = 24'sd0;
      endcase
      return v;
   endfunction

endpackage

[hdl/tfvc_ratio.sv]
// ---------------------------------------------------------------------------
// tfvc_ratio: exponential ratio unit
// Computes exp(-rate*ms/1000) as a Q0.16 ratio, 0..65536, over several cycles
// with one multiplier step and one bit-serial divide per series term, one divide bit per cycle.
// ---------------------------------------------------------------------------
module tfvc_ratio (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [7:0]  rate,
   input  logic [15:0] ms,
   output logic        done,
   output logic [16:0] ratio
);

   typedef enum logic [2:0] {
      S_IDLE, S_EXP, S_FRAC, S_TERM, S_DIV, S_FIN
   } state_type;

   state_type   state_ff;
   logic [23:0] a_ff;
   logic [40:0] p_ff;
   logic [30:0] y_ff;
   logic [31:0] sum_ff;   // signed Q.30, stays in 0..2^30
   logic [30:0] term_ff;
   logic [30:0] quo_ff;
   logic [30:0] rem_ff;
   logic [30:0] prod_ff;
   logic [3:0]  k_ff;
   logic [4:0]  bit_ff;
   logic        done_ff;
   logic [16:0] ratio_ff;

   logic [61:0] yt_mult;
   logic [31:0] rem_shift;
   logic [24:0] n_val;
   logic [31:0] sum_new;

   assign yt_mult   = 62'(term_ff) * 62'(y_ff);
   assign rem_shift = {rem_ff, prod_ff[bit_ff]};
   assign n_val     = p_ff[40:16];
   assign sum_new   = k_ff[0] ? (sum_ff - 32'(quo_ff)) : (sum_ff + 32'(quo_ff));

   // sequencer: exponent, ln2 fraction, eight series terms by restoring divide
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         // one-cycle pulse with the last term
         done_ff <= (state_ff == S_FIN) && (k_ff == 4'd8);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  a_ff     <= 24'(rate) * 24'(ms);
                  state_ff <= S_EXP;
               end
            end
            S_EXP: begin
               p_ff     <= (41'(a_ff) * 41'(tfvc_pkg::ExpScale) + 41'd512) >> 10;
               state_ff <= S_FRAC;
            end
            S_FRAC: begin
               y_ff     <= 31'((47'(p_ff[15:0]) * 47'(tfvc_pkg::Ln2Q30)) >> 16);
               sum_ff   <= 32'd1 << 30;
               term_ff  <= 31'd1 << 30;
               k_ff     <= 4'd1;
               state_ff <= S_TERM;
            end
            S_TERM: begin
               prod_ff  <= 31'(yt_mult >> 30);
               rem_ff   <= '0;
               quo_ff   <= '0;
               bit_ff   <= 5'd30;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (rem_shift >= 32'(k_ff)) begin
                  rem_ff <= 31'(rem_shift - 32'(k_ff));
                  quo_ff[bit_ff] <= 1'b1;
               end else begin
                  rem_ff <= rem_shift[30:0];
               end
               if (bit_ff == 5'd0) state_ff <= S_FIN;
               else bit_ff <= bit_ff - 5'd1;
            end
            S_FIN: begin
               sum_ff  <= sum_new;
               term_ff <= quo_ff;
               if (k_ff == 4'd8) begin
                  if (n_val >= 25'd17) ratio_ff <= '0;
                  else ratio_ff <= 17'((sum_new + (32'd1 << (13 + n_val[4:0])))
                                   >> (14 + n_val[4:0]));
                  state_ff <= S_IDLE;
               end else begin
                  k_ff     <= k_ff + 4'd1;
                  state_ff <= S_TERM;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign ratio = ratio_ff;

endmodule

[hdl/target_follow_velocity_controller.sv]
// ---------------------------------------------------------------------------
// target_follow_velocity_controller: polar follow controller
// Distance, bearing and smoothed linear / angular velocity commands.
// ---------------------------------------------------------------------------
// Usage:
//  req_ words carry a target position and the milliseconds since the last
//  word. Each accepted word yields one rsp_ word with the new linear and
//  angular commands, the distance, the bearing and the too_close flag.
//  The block works on one word at a time: the square root takes one result
//  bit per two radicand bits over a serial remainder, the bearing 16
//  CORDIC iterations, then the linear and angular ratios run one after the
//  other in the shared ratio unit (eight series terms, each a 31-step
//  bit-serial divide). A new word is taken only after the result of the
//  last one has been loaded into the output register.
//  req_tready is high only while the block is idle; a result waits in the
//  output register while rsp_tready is low, and the next result then waits.
//  Synchronous reset clears the stored commands to zero and the registers to
//  their defaults. csr_ writes take effect at once and should be done idle.
// ---------------------------------------------------------------------------
module target_follow_velocity_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // target_x, target_y, interval_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // linear_cmd, angular_cmd,
                                    // target_distance_out, target_angle
   output logic        rsp_tuser,   // too_close
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_SQRT, S_ROT, S_CORDIC, S_ANG, S_CMD, S_RLIN, S_RANG, S_MIX, S_OUT
   } state_type;

   state_type          state_ff;
   logic [14:0]        reg_ff [tfvc_pkg::RegCount];
   logic signed [15:0] x_ff, y_ff, prev_lin_ff, prev_ang_ff;
   logic [15:0]        ms_ff;
   logic [31:0]        sq_ff;
   logic [17:0]        rem_ff;
   logic [15:0]        root_ff;
   logic [3:0]         cnt_ff;
   logic signed [23:0] u_ff, w_ff, acc_ff;
   logic signed [15:0] ang_ff, lc_ff, ac_ff;
   logic [16:0]        rlin_ff, rang_ff;
   logic               close_ff, rstart_ff, rsp_valid_ff;
   logic [63:0]        rsp_data_ff;
   logic               rsp_user_ff;

   logic               rdone;
   logic [16:0]        rratio;
   logic [7:0]         rrate;
   logic [17:0]        trial;
   logic [17:0]        rem_next;
   logic signed [23:0] du, dw, acc_r;
   logic signed [16:0] range_err, lin_c, twice_ang, ang_c;
   logic signed [16:0] blin, bang;
   logic signed [35:0] mix_lin, mix_ang;
   logic               load_out;

   tfvc_ratio u_ratio (
      .clock (clock), .reset (reset), .start (rstart_ff), .rate (rrate),
      .ms (ms_ff), .done (rdone), .ratio (rratio)
   );

   always_comb begin
      rrate = 8'(reg_ff[tfvc_pkg::REG_BLEND_LIN]);
      if (state_ff == S_RLIN)
         rrate = close_ff ? 8'(reg_ff[tfvc_pkg::REG_DECAY_LIN])
                          : 8'(reg_ff[tfvc_pkg::REG_BLEND_LIN]);
      else
         rrate = close_ff ? 8'(reg_ff[tfvc_pkg::REG_DECAY_ANG])
                          : 8'(reg_ff[tfvc_pkg::REG_BLEND_ANG]);
   end

   // square root: two radicand bits per cycle
   assign rem_next = {rem_ff[15:0], sq_ff[31:30]};
   assign trial    = {root_ff[15:0], 2'b01};

   // CORDIC shifts
   assign du    = w_ff >>> cnt_ff;
   assign dw    = u_ff >>> cnt_ff;
   assign acc_r = (acc_ff + 24'sd8) >>> 4;

   // proportional commands with clamp
   assign range_err = $signed({1'b0, root_ff}) -
                      $signed({2'b0, reg_ff[tfvc_pkg::REG_TARGET_DIST]});
   assign twice_ang = 17'(ang_ff) <<< 1;
   always_comb begin
      blin = $signed({2'b0, reg_ff[tfvc_pkg::REG_MAX_LIN]});
      bang = $signed({2'b0, reg_ff[tfvc_pkg::REG_MAX_ANG]});
      if (range_err > blin) lin_c = blin;
      else if (range_err < -blin) lin_c = -blin;
      else lin_c = range_err;
      if (twice_ang > bang) ang_c = bang;
      else if (twice_ang < -bang) ang_c = -bang;
      else ang_c = twice_ang;
   end

   // blend: cmd*(1-r) + prev*r, rounded half up at Q.16
   assign mix_lin = 36'(lc_ff) * $signed({1'b0, 17'd65536 - rlin_ff}) +
                    36'(prev_lin_ff) * $signed({1'b0, rlin_ff}) + 36'sd32768;
   assign mix_ang = 36'(ac_ff) * $signed({1'b0, 17'd65536 - rang_ff}) +
                    36'(prev_ang_ff) * $signed({1'b0, rang_ff}) + 36'sd32768;

   // output register loads when empty or being drained
   assign load_out = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_ff[tfvc_pkg::REG_TARGET_DIST] <= 15'd4096;
         reg_ff[tfvc_pkg::REG_STOP_DIST]   <= 15'd1638;
         reg_ff[tfvc_pkg::REG_MAX_LIN]     <= 15'd1229;
         reg_ff[tfvc_pkg::REG_MAX_ANG]     <= 15'd6144;
         reg_ff[tfvc_pkg::REG_DECAY_LIN]   <= 15'd3;
         reg_ff[tfvc_pkg::REG_DECAY_ANG]   <= 15'd15;
         reg_ff[tfvc_pkg::REG_BLEND_LIN]   <= 15'd6;
         reg_ff[tfvc_pkg::REG_BLEND_ANG]   <= 15'd20;
      end else if (csr_we) begin
         if (csr_index[2]) reg_ff[csr_index] <= {7'd0, csr_wdata[7:0]};
         else reg_ff[csr_index] <= csr_wdata;
      end
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rstart_ff    <= 1'b0;
         prev_lin_ff  <= '0;
         prev_ang_ff  <= '0;
      end else begin
         rstart_ff    <= (state_ff == S_CMD) || ((state_ff == S_RLIN) && rdone);
         rsp_valid_ff <= load_out || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  x_ff     <= $signed(req_tdata[15:0]);
                  y_ff     <= $signed(req_tdata[31:16]);
                  ms_ff    <= req_tdata[47:32];
                  sq_ff    <= 32'($signed(req_tdata[15:0]) * $signed(req_tdata[15:0]))
                            + 32'($signed(req_tdata[31:16]) * $signed(req_tdata[31:16]));
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (rem_next >= trial) begin
                  rem_ff  <= rem_next - trial;
                  root_ff <= {root_ff[14:0], 1'b1};
               end else begin
                  rem_ff  <= rem_next;
                  root_ff <= {root_ff[14:0], 1'b0};
               end
               sq_ff <= sq_ff << 2;
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) state_ff <= S_ROT;
            end
            S_ROT: begin
               // quarter turn into the right half plane
               cnt_ff <= '0;
               if (y_ff < 0) begin
                  if (x_ff >= 0) begin
                     u_ff <= 24'(x_ff) <<< 4; w_ff <= -(24'(y_ff) <<< 4);
                     acc_ff <= tfvc_pkg::QuarterPiQ16;
                  end else begin
                     u_ff <= -(24'(x_ff) <<< 4); w_ff <= 24'(y_ff) <<< 4;
                     acc_ff <= -tfvc_pkg::QuarterPiQ16;
                  end
               end else begin
                  u_ff <= 24'(y_ff) <<< 4; w_ff <= 24'(x_ff) <<< 4;
                  acc_ff <= '0;
               end
               state_ff <= S_CORDIC;
            end
            S_CORDIC: begin
               if (w_ff >= 0) begin
                  u_ff <= u_ff + du; w_ff <= w_ff - dw;
                  acc_ff <= acc_ff + tfvc_pkg::atan_entry(cnt_ff);
               end else begin
                  u_ff <= u_ff - du; w_ff <= w_ff + dw;
                  acc_ff <= acc_ff - tfvc_pkg::atan_entry(cnt_ff);
               end
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) state_ff <= S_ANG;
            end
            S_ANG: begin
               if (x_ff == 0 && y_ff == 0) ang_ff <= '0;
               else if (acc_r > 24'(tfvc_pkg::AngLimit)) ang_ff <= tfvc_pkg::AngLimit;
               else if (acc_r < -24'(tfvc_pkg::AngLimit)) ang_ff <= -tfvc_pkg::AngLimit;
               else ang_ff <= 16'(acc_r);
               close_ff <= {1'b0, root_ff} < {2'b0, reg_ff[tfvc_pkg::REG_STOP_DIST]};
               state_ff <= S_CMD;
            end
            S_CMD: begin
               lc_ff <= close_ff ? 16'sd0 : 16'(lin_c);
               ac_ff <= close_ff ? 16'sd0 : 16'(ang_c);
               state_ff  <= S_RLIN;
            end
            S_RLIN: begin
               if (rdone) begin
                  rlin_ff   <= rratio;
                  state_ff  <= S_RANG;
               end
            end
            S_RANG: begin
               if (rdone) begin
                  rang_ff  <= rratio;
                  state_ff <= S_MIX;
               end
            end
            S_MIX: begin
               prev_lin_ff <= 16'(mix_lin >>> 16);
               prev_ang_ff <= 16'(mix_ang >>> 16);
               state_ff    <= S_OUT;
            end
            S_OUT: begin
               if (load_out) begin
                  rsp_data_ff  <= {1'b0, ang_ff[14:0], root_ff, prev_ang_ff, prev_lin_ff};
                  rsp_user_ff  <= close_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a word is accepted only while idle, and never while busy
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SQRT))
      else $error("accepted word did not start the root");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      rdone |-> (rratio <= 17'd65536))
      else $error("ratio above one");

endmodule
